// File: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared widths, request and status codes, and the layout of a page head word.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_RANK_DEF   = 16;
  localparam int POOL_PAGES_DEF = 32768;

  localparam int TYPE_W = 2;
  localparam int RANK_W = 5;
  localparam int PAGE_W = 15;
  localparam int CNT_W  = 16;
  localparam int STAT_W = 2;
  localparam int POOL_W = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [0:0] REG_POOL_PAGES = 1'b0;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVAL   = 2'd1,
    ST_NOSPACE = 2'd2
  } stat_t;

  typedef struct packed {
    logic              free;
    logic [RANK_W-1:0] rank;
  } hd_t;

  localparam int HD_W = RANK_W + 1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] page;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

// File: src/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Walks the page head memory one access at a time with a shared size shifter
// to allocate, free with merging, query, and clear the pool.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; #(
  parameter int MAX_RANK_NUM = MAX_RANK_DEF,
  parameter int POOL_PAGES   = POOL_PAGES_DEF,
  parameter int PW           = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr_start,
  input  logic [RANK_W-1:0] top_rank,
  input  logic [PW:0]       area,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TYPE_W-1:0] in_type,
  input  logic [RANK_W-1:0] in_rank,
  input  logic [PAGE_W-1:0] in_page,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int CW     = $clog2(POOL_PAGES + 1);
  localparam int CNT_D  = 1 << RANK_W;

  typedef enum logic [16:0] {
    S_CLEAR   = 17'h00001,
    S_SEED    = 17'h00002,
    S_IDLE    = 17'h00004,
    S_RSRCH   = 17'h00008,
    S_SCAN_RD = 17'h00010,
    S_SCAN_CK = 17'h00020,
    S_SPL_DEC = 17'h00040,
    S_SPLIT   = 17'h00080,
    S_FRD     = 17'h00100,
    S_FCK     = 17'h00200,
    S_MRG_RD  = 17'h00400,
    S_MRG_CK  = 17'h00800,
    S_MRG_CLR = 17'h01000,
    S_FSET    = 17'h02000,
    S_QRD     = 17'h04000,
    S_QCK     = 17'h08000,
    S_FIN     = 17'h10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] r_r, r_nxt;
  logic [RANK_W-1:0] brank_r, brank_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [PW-1:0]     b_r, b_nxt;
  logic [PW:0]       i_r, i_nxt;
  logic [PW-1:0]     clr_r, clr_nxt;
  stat_t             st_r, st_nxt;

  logic [CW-1:0]     cnt_r [CNT_D];
  logic [RANK_W-1:0] cnt_ri, cnt_wi;
  logic [CW-1:0]     cnt_rd, cnt_wd;
  logic              cnt_we, cnt_clr;

  logic              mem_we;
  logic [PW-1:0]     mem_waddr, mem_raddr;
  logic [HD_W-1:0]   mem_wdata, mem_rdata;
  hd_t               hd;

  logic [RANK_W-1:0] sh_amt;
  logic [PW:0]       sz;
  logic [PW:0]       i_sum;
  logic              count_ok;

  bpa_ram #(.WIDTH(HD_W), .DEPTH(POOL_PAGES), .AW(PW)) u_head_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign hd       = hd_t'(mem_rdata);
  assign cnt_rd   = cnt_r[cnt_ri];
  assign sh_amt   = (state_r == S_SPLIT) ? (r_r - RANK_W'(2)) : (r_r - RANK_W'(1));
  assign sz       = (PW+1)'(1) << sh_amt;
  assign i_sum    = i_r + sz;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    type_nxt  = type_r;
    rank_nxt  = rank_r;
    r_nxt     = r_r;
    brank_nxt = brank_r;
    p_nxt     = p_r;
    b_nxt     = b_r;
    i_nxt     = i_r;
    clr_nxt   = clr_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    mem_waddr = p_r;
    mem_wdata = '0;
    mem_raddr = p_r;
    cnt_we    = 1'b0;
    cnt_wi    = r_r;
    cnt_wd    = cnt_rd;
    cnt_ri    = r_r;
    cnt_clr   = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        cnt_clr   = 1'b1;
        clr_nxt   = clr_r + PW'(1);
        if (clr_r == PW'(POOL_PAGES - 1)) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        if (top_rank != '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {1'b1, top_rank};
          cnt_we    = 1'b1;
          cnt_wi    = top_rank;
          cnt_wd    = CW'(1);
        end
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          type_nxt  = in_type;
          rank_nxt  = in_rank;
          p_nxt     = PW'({2'b00, in_page});
          brank_nxt = '0;
          st_nxt    = ST_OK;
          case (in_type)
            REQ_ALLOC: begin
              if (in_rank == '0 || in_rank > RANK_W'(MAX_RANK_NUM)) begin
                st_nxt    = ST_INVAL;
                state_nxt = S_FIN;
              end else if (in_rank > top_rank) begin
                st_nxt    = ST_NOSPACE;
                state_nxt = S_FIN;
              end else begin
                r_nxt     = in_rank;
                state_nxt = S_RSRCH;
              end
            end
            REQ_FREE: begin
              if ({2'b00, in_page} >= 17'(area)) begin
                st_nxt    = ST_INVAL;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FRD;
              end
            end
            REQ_QUERY: begin
              if ({2'b00, in_page} >= 17'(area)) begin
                st_nxt    = ST_INVAL;
                state_nxt = S_FIN;
              end else begin
                r_nxt     = top_rank;
                state_nxt = S_QRD;
              end
            end
            default: begin
              st_nxt    = ST_INVAL;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RSRCH: begin
        if (r_r > top_rank) begin
          st_nxt    = ST_NOSPACE;
          state_nxt = S_FIN;
        end else if (cnt_rd == '0) begin
          r_nxt = r_r + RANK_W'(1);
        end else begin
          i_nxt     = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        mem_raddr = PW'(i_r);
        state_nxt = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (hd.free && hd.rank == r_r) begin
          p_nxt     = PW'(i_r);
          state_nxt = S_SPL_DEC;
        end else begin
          i_nxt = i_sum;
          if (i_sum >= area) begin
            st_nxt    = ST_NOSPACE;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SPL_DEC: begin
        cnt_we    = 1'b1;
        cnt_wd    = cnt_rd - CW'(1);
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (r_r > rank_r) begin
          cnt_ri    = r_r - RANK_W'(1);
          cnt_wi    = r_r - RANK_W'(1);
          cnt_we    = 1'b1;
          cnt_wd    = cnt_rd + CW'(1);
          mem_we    = 1'b1;
          mem_waddr = p_r + PW'(sz);
          mem_wdata = {1'b1, r_r - RANK_W'(1)};
          r_nxt     = r_r - RANK_W'(1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = p_r;
          mem_wdata = {1'b0, rank_r};
          state_nxt = S_FIN;
        end
      end
      S_FRD: begin
        state_nxt = S_FCK;
      end
      S_FCK: begin
        if (hd.rank == '0 || hd.free) begin
          st_nxt    = ST_INVAL;
          state_nxt = S_FIN;
        end else begin
          r_nxt     = hd.rank;
          state_nxt = S_MRG_RD;
        end
      end
      S_MRG_RD: begin
        if (r_r >= top_rank) begin
          state_nxt = S_FSET;
        end else begin
          b_nxt     = p_r ^ PW'(sz);
          mem_raddr = p_r ^ PW'(sz);
          state_nxt = S_MRG_CK;
        end
      end
      S_MRG_CK: begin
        if (hd.free && hd.rank == r_r) begin
          cnt_we    = 1'b1;
          cnt_wd    = cnt_rd - CW'(1);
          mem_we    = 1'b1;
          mem_waddr = b_r;
          state_nxt = S_MRG_CLR;
        end else begin
          state_nxt = S_FSET;
        end
      end
      S_MRG_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        if (b_r < p_r) begin
          p_nxt = b_r;
        end
        r_nxt     = r_r + RANK_W'(1);
        state_nxt = S_MRG_RD;
      end
      S_FSET: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        mem_wdata = {1'b1, r_r};
        cnt_we    = 1'b1;
        cnt_wd    = cnt_rd + CW'(1);
        state_nxt = S_FIN;
      end
      S_QRD: begin
        if (r_r == '0) begin
          st_nxt    = ST_INVAL;
          state_nxt = S_FIN;
        end else begin
          mem_raddr = PW'({1'b0, p_r} & ~(sz - (PW+1)'(1)));
          state_nxt = S_QCK;
        end
      end
      S_QCK: begin
        if (hd.rank == r_r) begin
          brank_nxt = r_r;
          state_nxt = S_FIN;
        end else begin
          r_nxt     = r_r - RANK_W'(1);
          state_nxt = S_QRD;
        end
      end
      S_FIN: begin
        cnt_ri    = rank_r;
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
    if (clr_start) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
    end
  end

  assign count_ok = (type_r == REQ_ALLOC || type_r == REQ_FREE || type_r == REQ_QUERY)
                    && rank_r != '0 && rank_r <= RANK_W'(MAX_RANK_NUM)
                    && rank_r <= top_rank;

  always_comb begin
    res.status = st_r;
    res.page   = (type_r == REQ_ALLOC && st_r == ST_OK) ? PAGE_W'(p_r) : '0;
    res.rank   = brank_r;
    res.count  = count_ok ? CNT_W'(cnt_rd) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r  <= type_nxt;
    rank_r  <= rank_nxt;
    r_r     <= r_nxt;
    brank_r <= brank_nxt;
    p_r     <= p_nxt;
    b_r     <= b_nxt;
    i_r     <= i_nxt;
    st_r    <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_clr) begin
      for (int k = 0; k < CNT_D; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (cnt_we) begin
      cnt_r[cnt_wi] <= cnt_wd;
    end
  end

  a_take_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPL_DEC |-> cnt_rd != '0)
    else $error("split taken from an empty rank");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN_CK |-> i_r < area)
    else $error("scan ran past the managed area");

  a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && type_r == REQ_ALLOC && st_r == ST_OK)
      |-> (({1'b0, p_r} & (sz - (PW+1)'(1))) == '0))
    else $error("allocated block is not aligned to its size");

  a_buddy_differs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MRG_CK |-> b_r != p_r)
    else $error("buddy equals the block itself");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_ready && !clr_start) |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after a result");

endmodule

// File: src/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates, frees and queries power-of-two page blocks over a configured pool.
//
//   Channel  Direction  Handshake            Contents
//   cfg      in/out     psel/penable/pready  pool_pages register at 0x0
//   in       in         in_valid/in_ready    req_type, req_rank, page_index
//   out      out        out_valid/out_ready  status, block_page, block_rank,
//                                            free_blocks
//
// A word rejected at once goes straight to the result with no head memory
// access. Each head memory access goes through the single read port: an
// allocate scans aligned heads at the first rank at or above its own that has
// a free block, a free reads one buddy per merge step and a query one head per
// rank from the top down. After reset and after each write of pool_pages the
// head memory is cleared with in_ready low. A result waits in the output
// register while out_ready is low; a further word is accepted meanwhile.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int MAX_RANK_NUM = MAX_RANK_DEF,
  parameter int POOL_PAGES   = POOL_PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TYPE_W-1:0] in_req_type,
  input  logic [RANK_W-1:0] in_req_rank,
  input  logic [PAGE_W-1:0] in_page_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [PAGE_W-1:0] out_block_page,
  output logic [RANK_W-1:0] out_block_rank,
  output logic [CNT_W-1:0]  out_free_blocks
);

  localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;

  function automatic logic [RANK_W-1:0] top_rank_of(input logic [16:0] pages);
    logic [RANK_W-1:0] mr;
    mr = '0;
    for (int r = 1; r <= MAX_RANK_NUM; r++) begin
      if ((17'(1) << (r - 1)) <= pages) begin
        mr = RANK_W'(r);
      end
    end
    return mr;
  endfunction

  function automatic logic [PW:0] area_of(input logic [RANK_W-1:0] mr);
    return (mr == '0) ? '0 : ((PW+1)'(1) << (mr - RANK_W'(1)));
  endfunction

  localparam logic [16:0] POOL_MAX = 17'(POOL_PAGES);

  logic [POOL_W-1:0] pool_r;
  logic [RANK_W-1:0] top_rank_r;
  logic [PW:0]       area_r;
  logic              cfg_we;
  logic [16:0]       pages_eff;
  logic [RANK_W-1:0] mr_new;

  logic              res_valid, res_ready;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite
                      && cfg_paddr[CFG_AW-1:2] == REG_POOL_PAGES;
  assign pages_eff  = ({1'b0, cfg_pwdata[POOL_W-1:0]} > POOL_MAX) ? POOL_MAX
                      : {1'b0, cfg_pwdata[POOL_W-1:0]};
  assign mr_new     = top_rank_of(pages_eff);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_POOL_PAGES)
                      ? {{(CFG_DW-POOL_W){1'b0}}, pool_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r     <= POOL_W'(POOL_PAGES);
      top_rank_r <= top_rank_of(POOL_MAX);
      area_r     <= area_of(top_rank_of(POOL_MAX));
    end else if (cfg_we) begin
      pool_r     <= cfg_pwdata[POOL_W-1:0];
      top_rank_r <= mr_new;
      area_r     <= area_of(mr_new);
    end
  end

  bpa_ctrl #(
    .MAX_RANK_NUM (MAX_RANK_NUM),
    .POOL_PAGES   (POOL_PAGES),
    .PW           (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (cfg_we),
    .top_rank  (top_rank_r),
    .area      (area_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_type   (in_req_type),
    .in_rank   (in_req_rank),
    .in_page   (in_page_index),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_block_page  = out_res_r.page;
  assign out_block_rank  = out_res_r.rank;
  assign out_free_blocks = out_res_r.count;

endmodule
